@@ sv/fscs_pkg.sv @@
// Shared types, signature tables and helper functions for the signature carver scanner.
package fscs_pkg;

  localparam int MIN_TEXT_DEF   = 2048;
  localparam int RING_DEPTH_DEF = 4096;
  localparam int SIG_SPAN       = 16;
  localparam int NUM_SIGS       = 14;
  localparam int OFF_W          = 48;
  localparam int LEN_W          = 26;
  localparam int TLEN_W         = 24;
  localparam int EVQ_DEPTH      = 4;
  localparam int OUTQ_DEPTH     = 4;
  localparam int APB_AW         = 3;
  localparam int MB             = 1048576;

  localparam logic [TLEN_W-1:0] MAX_TEXT_LEN_RST = 24'h200000;

  typedef enum logic [0:0] {
    REG_MAX_TEXT_LEN = 1'b0
  } reg_idx_t;

  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    KIND_JPG    = 4'd0,
    KIND_PNG    = 4'd1,
    KIND_GIF    = 4'd2,
    KIND_WEBP   = 4'd3,
    KIND_PDF    = 4'd4,
    KIND_DOC    = 4'd5,
    KIND_ZIP    = 4'd6,
    KIND_RAR    = 4'd7,
    KIND_7Z     = 4'd8,
    KIND_MP3    = 4'd9,
    KIND_MKV    = 4'd10,
    KIND_MP4    = 4'd11,
    KIND_SQLITE = 4'd12,
    KIND_EXE    = 4'd13,
    KIND_TEXT   = 4'd14
  } kind_t;

  typedef logic [SIG_SPAN-1:0][7:0] win_t;
  typedef logic [SIG_SPAN-1:0]      mask_t;
  typedef logic [7:0]               byte_row_t [SIG_SPAN];

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } scan_res_t;

  // one scan position as classified by the front end
  typedef struct packed {
    logic  scan;
    logic  hit;
    kind_t kind;
    logic  print0;
    logic  open_ok;
    logic  end_close;
  } event_t;

  typedef struct packed {
    kind_t             kind;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } res_pair_t;

  // signature bytes, byte 0 first; unused tail bytes are don't-care
  localparam byte_row_t SIG_PAT [NUM_SIGS] = '{
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h57, 8'h45, 8'h42, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1, 8'h1A, 8'hE1,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'h74, 8'h79, 8'h70,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h51, 8'h4C, 8'h69, 8'h74, 8'h65, 8'h20, 8'h66,
      8'h6F, 8'h72, 8'h6D, 8'h61, 8'h74, 8'h20, 8'h33, 8'h00},
    '{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // bit k set: byte k must match
  localparam logic [SIG_SPAN-1:0] SIG_CARE [NUM_SIGS] = '{
    16'h0007, 16'h000F, 16'h003F, 16'h0F0F, 16'h000F, 16'h00FF, 16'h000F,
    16'h003F, 16'h003F, 16'h0007, 16'h000F, 16'h00F0, 16'hFFFF, 16'h000B
  };

  function automatic logic is_printable(input logic [7:0] c);
    return (c == 8'd9) || (c == 8'd10) || (c == 8'd13) || ((c >= 8'd32) && (c <= 8'd126));
  endfunction

  // first matching signature wins; bytes not yet held count as mismatches
  function automatic scan_res_t sig_scan(input win_t w, input mask_t v);
    scan_res_t r;
    logic      m;
    r.hit  = 1'b0;
    r.kind = KIND_JPG;
    for (int s = NUM_SIGS - 1; s >= 0; s--) begin
      m = 1'b1;
      for (int k = 0; k < SIG_SPAN; k++) begin
        if (SIG_CARE[s][k] && (!v[k] || (w[k] != SIG_PAT[s][k]))) begin
          m = 1'b0;
        end
      end
      if (m) begin
        r.hit  = 1'b1;
        r.kind = kind_t'(4'(s));
      end
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] sig_size(input kind_t k);
    logic [LEN_W-1:0] sz;
    unique case (k) inside
      KIND_JPG, KIND_PNG:          sz = LEN_W'(3 * MB);
      KIND_GIF, KIND_WEBP:         sz = LEN_W'(2 * MB);
      KIND_PDF, KIND_SQLITE:       sz = LEN_W'(10 * MB);
      KIND_DOC, KIND_EXE:          sz = LEN_W'(5 * MB);
      KIND_ZIP, KIND_RAR, KIND_7Z: sz = LEN_W'(15 * MB);
      KIND_MP3:                    sz = LEN_W'(8 * MB);
      KIND_MKV, KIND_MP4:          sz = LEN_W'(50 * MB);
      default:                     sz = '0;
    endcase
    return sz;
  endfunction

endpackage

@@ sv/file_signature_carver_scan.sv @@
// Top level of the file signature carver scanner: ports, config register, wiring.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------------
//  input     | push / full             | command, data_byte
//  results   | pop / empty             | hit_kind, hit_offset, carve_length, last_result
//  config    | psel, penable, pwrite   | paddr, pwdata, prdata (max_text_len at 0x0)
//
//  One transaction per clock on the input while full is low.
//  A position is decided once the lookahead holds min(MIN_TEXT+1, RING_DEPTH) bytes
//  (never fewer than 16), so results trail their bytes by that many transactions, passing
//  through the event queue and the back end. The ring has one write and one read port.
//  full rises only when the event queue fills, i.e. when the result queue lacks room
//  for two results and the back end stalls; the sides stall independently.
//  Reset is synchronous and needs no clearing pass: ring contents are never read
//  before being written.
module file_signature_carver_scan import fscs_pkg::*; #(
  parameter int MIN_TEXT   = MIN_TEXT_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input queue side
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [7:0]        data_byte,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic [3:0]        hit_kind,
  output logic [OFF_W-1:0]  hit_offset,
  output logic [LEN_W-1:0]  carve_length,
  output logic              last_result,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [TLEN_W-1:0] max_text_len;
  logic              take;
  logic              fe_valid;
  event_t            fe_ev;
  logic              evq_empty, evq_pop;
  event_t            evq_head;
  logic              room2;
  res_pair_t         be_wr;
  result_t           out_res;

  // Config: single register, word-aligned; paddr[2] selects the register index.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_text_len <= MAX_TEXT_LEN_RST;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx_t'(paddr[2]) == REG_MAX_TEXT_LEN)) begin
      max_text_len <= pwdata[TLEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_MAX_TEXT_LEN: prdata = {{(32 - TLEN_W){1'b0}}, max_text_len};
      default:          prdata = '0;
    endcase
  end

  // A transaction is taken whenever the event queue has a free slot, whether or
  // not this byte decides a position.
  assign take = push && !full;

  fscs_front #(
    .MIN_TEXT   (MIN_TEXT),
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .command   (command),
    .data_byte (data_byte),
    .ev_valid  (fe_valid),
    .ev        (fe_ev)
  );

  fscs_evq #(
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_valid),
    .din   (fe_ev),
    .full  (full),
    .pop   (evq_pop),
    .empty (evq_empty),
    .dout  (evq_head)
  );

  // Back end retires one event per cycle while the result queue has room for two, producing up to two results.
  fscs_back #(
    .MIN_TEXT (MIN_TEXT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ev_valid     (!evq_empty),
    .ev           (evq_head),
    .ev_pop       (evq_pop),
    .max_text_len (max_text_len),
    .room2        (room2),
    .wr           (be_wr)
  );

  fscs_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr       (be_wr),
    .room2    (room2),
    .pop      (pop),
    .empty    (empty),
    .head_res (out_res)
  );

  assign hit_kind     = out_res.kind;
  assign hit_offset   = out_res.offset;
  assign carve_length = out_res.length;
  assign last_result  = out_res.last;

endmodule

@@ sv/fscs_front.sv @@
// Front end: lookahead ring, head window and per-position classification.
module fscs_front import fscs_pkg::*; #(
  parameter int MIN_TEXT   = MIN_TEXT_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       command,
  input  logic [7:0] data_byte,
  output logic       ev_valid,
  output event_t     ev
);

  localparam int AW        = $clog2(RING_DEPTH);
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int WANT      = (MIN_TEXT + 1 > SIG_SPAN) ? MIN_TEXT + 1 : SIG_SPAN;
  localparam int LOOKAHEAD = (WANT < RING_DEPTH) ? WANT : RING_DEPTH;

  logic [7:0]       ring [RING_DEPTH];
  logic [AW-1:0]    wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] fill, fill_next, fill_pushed;
  logic [CNT_W-1:0] tpc, tpc_next, tpc_pushed;
  win_t             win, win_next, win_pushed;
  mask_t            vmask;
  logic [7:0]       rd_data, fwd_data, far_byte;
  logic             fwd, fwd_next;
  logic             is_data, is_drain, pop;
  scan_res_t        sres;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    is_data     = take && (command == CMD_DATA);
    is_drain    = take && (command == CMD_DRAIN);
    fill_pushed = fill + CNT_W'(is_data);
    if (is_data) begin
      tpc_pushed = is_printable(data_byte) ? tpc + 1'b1 : '0;
    end else begin
      tpc_pushed = tpc;
    end
    pop = (is_data && (fill_pushed == CNT_W'(LOOKAHEAD))) || (is_drain && (fill != '0));

    for (int i = 0; i < SIG_SPAN; i++) begin
      win_pushed[i] = (is_data && (fill == CNT_W'(i))) ? data_byte : win[i];
      vmask[i]      = fill_pushed > CNT_W'(i);
    end

    // byte just beyond the window, from the ring or the last write
    far_byte = (fill > CNT_W'(SIG_SPAN)) ? (fwd ? fwd_data : rd_data) : data_byte;
    win_next = pop ? {far_byte, win_pushed[SIG_SPAN-1:1]} : win_pushed;

    fill_next   = fill_pushed - CNT_W'(pop);
    tpc_next    = (tpc_pushed > fill_next) ? fill_next : tpc_pushed;
    wr_ptr_next = is_data ? ptr_inc(wr_ptr) : wr_ptr;
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    fwd_next    = is_data && (wr_ptr == rd_ptr_next);

    sres         = sig_scan(win_pushed, vmask);
    ev.scan      = pop;
    ev.hit       = sres.hit;
    ev.kind      = sres.kind;
    ev.print0    = is_printable(win_pushed[0]);
    ev.open_ok   = ({{(32 - CNT_W){1'b0}}, fill_pushed} > 32'(MIN_TEXT)) &&
                   (tpc_pushed >= fill_pushed);
    ev.end_close = is_drain && (fill <= CNT_W'(1));
    ev_valid     = pop || ev.end_close;
  end

  always_ff @(posedge clk) begin
    if (is_data) begin
      ring[wr_ptr] <= data_byte;
    end
    rd_data  <= ring[rd_ptr_next];
    fwd_data <= data_byte;
    win      <= win_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= AW'(SIG_SPAN);
      fill   <= '0;
      tpc    <= '0;
      fwd    <= 1'b0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
      tpc    <= tpc_next;
      fwd    <= fwd_next;
    end
  end

  a_steady_fill: assert property (@(posedge clk) disable iff (rst)
    (is_data && (fill == CNT_W'(LOOKAHEAD - 1))) |=> (fill == CNT_W'(LOOKAHEAD - 1)))
    else $error("lookahead level not held in steady state");

  a_tpc_bound: assert property (@(posedge clk) disable iff (rst) tpc <= fill)
    else $error("printable count exceeds held bytes");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (is_drain && (fill <= CNT_W'(1))) |=> (fill == '0))
    else $error("final drain left bytes pending");

endmodule

@@ sv/fscs_evq.sv @@
// Short event queue between the front end and the back end.
module fscs_evq import fscs_pkg::*; #(
  parameter int DEPTH = EVQ_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t din,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output event_t dout
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  event_t        slots [DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign dout    = slots[head];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

@@ sv/fscs_back.sv @@
// Back end: text-run tracking, offsets and result formation.
module fscs_back import fscs_pkg::*; #(
  parameter int MIN_TEXT = MIN_TEXT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ev_valid,
  input  event_t            ev,
  output logic              ev_pop,
  input  logic [TLEN_W-1:0] max_text_len,
  input  logic              room2,
  output res_pair_t         wr
);

  logic [OFF_W-1:0]  scan_offset, scan_offset_next;
  logic [OFF_W-1:0]  text_start, text_start_next;
  logic [TLEN_W-1:0] text_len, text_len_next, len_mid;
  logic              in_run, in_run_next;
  logic              take, skip, closing, sig_hit, opening, run_mid, ending;
  logic [1:0]        n;
  result_t           text_res, sig_res;

  always_comb begin
    take    = ev_valid && room2;
    ev_pop  = take;
    skip    = ev.scan && in_run && ev.print0 && (text_len < max_text_len);
    closing = ev.scan && in_run && !skip;
    sig_hit = ev.scan && !skip && ev.hit;
    opening = ev.scan && !skip && !ev.hit && ev.open_ok &&
              (max_text_len > TLEN_W'(MIN_TEXT));
    len_mid = skip ? text_len + 1'b1 : text_len;
    run_mid = skip || opening || (in_run && !ev.scan);
    ending  = ev.end_close && run_mid;
    n       = 2'(closing) + 2'(sig_hit) + 2'(ending);

    text_res.kind   = KIND_TEXT;
    text_res.offset = text_start;
    text_res.length = {{(LEN_W - TLEN_W){1'b0}}, len_mid};
    text_res.last   = 1'b0;
    sig_res.kind    = ev.kind;
    sig_res.offset  = scan_offset;
    sig_res.length  = sig_size(ev.kind);
    sig_res.last    = 1'b1;

    // a closing run goes out ahead of a hit at the same position
    wr.first      = (sig_hit && !closing) ? sig_res : text_res;
    wr.first.last = n == 2'd1;
    wr.second     = sig_res;
    wr.count      = take ? n : 2'd0;

    scan_offset_next = ev.scan ? scan_offset + 1'b1 : scan_offset;
    in_run_next      = run_mid && !ending;
    text_start_next  = opening ? scan_offset : text_start;
    text_len_next    = opening ? TLEN_W'(1) : len_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_offset <= '0;
      in_run      <= 1'b0;
      text_start  <= '0;
      text_len    <= '0;
    end else if (take) begin
      scan_offset <= scan_offset_next;
      in_run      <= in_run_next;
      text_start  <= text_start_next;
      text_len    <= text_len_next;
    end
  end

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (wr.count == 2'd2) |-> ((wr.first.kind == KIND_TEXT) && (wr.second.kind != KIND_TEXT)))
    else $error("two results without a run close ahead of a hit");

endmodule

@@ sv/fscs_outq.sv @@
// Result queue, up to two writes per cycle, one read.
module fscs_outq import fscs_pkg::*; #(
  parameter int DEPTH = OUTQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t wr,
  output logic      room2,
  input  logic      pop,
  output logic      empty,
  output result_t   head_res
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t       slots [DEPTH];
  logic [PW-1:0] head, tail, tail_1;
  logic [CW-1:0] count;
  logic          do_pop;

  assign empty    = count == '0;
  assign room2    = count <= CW'(DEPTH - 2);
  assign head_res = slots[head];
  assign do_pop   = pop && !empty;
  assign tail_1   = tail + 1'b1;

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      slots[tail] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      slots[tail_1] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PW'(wr.count);
      head  <= head + PW'(do_pop);
      count <= count + CW'(wr.count) - CW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr.count != 2'd0) |-> (({1'b0, count} + (CW + 1)'(wr.count)) <= (CW + 1)'(DEPTH)))
    else $error("result queue overrun");

endmodule
